// File: hw/rtl/lkv_pkg.sv
package lkv_pkg;

  localparam int unsigned EntriesDefault = 8;
  localparam int unsigned CapW           = 4;
  localparam int unsigned KeyW           = 32;
  localparam int unsigned ValW           = 32;
  localparam int unsigned InDataW        = 64;
  localparam int unsigned OutDataW       = 72;
  localparam int unsigned OutPadW        = OutDataW - (2 * 32 + 2);

  localparam logic [CapW-1:0] CapReset  = 4'd5;
  localparam logic [ValW-1:0] MissValue = 32'hFFFF_FFFF;

  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StUpdate
  } state_e;

  typedef struct packed {
    logic hit;
    logic old_found;
    logic free_found;
  } flags_t;

endpackage

// File: hw/rtl/lkv_ram.sv
module lkv_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lkv_search.sv
module lkv_search #(
  parameter int unsigned Entries = lkv_pkg::EntriesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clr_i,
  input  logic                        en_i,
  input  logic [lkv_pkg::KeyW-1:0]    key_i,
  input  logic [lkv_pkg::KeyW-1:0]    rd_key_i,
  input  logic [lkv_pkg::ValW-1:0]    rd_val_i,
  input  logic                        ent_vld_i,
  input  logic [$clog2(Entries)-1:0]  ent_age_i,
  input  logic [$clog2(Entries)-1:0]  ent_idx_i,
  output lkv_pkg::flags_t             flags_o,
  output logic [$clog2(Entries)-1:0]  hit_idx_o,
  output logic [$clog2(Entries)-1:0]  hit_age_o,
  output logic [lkv_pkg::ValW-1:0]    hit_val_o,
  output logic [$clog2(Entries)-1:0]  old_idx_o,
  output logic [lkv_pkg::KeyW-1:0]    old_key_o,
  output logic [$clog2(Entries)-1:0]  free_idx_o
);

  localparam int unsigned IdxW = $clog2(Entries);

  lkv_pkg::flags_t           flags_q, flags_d;
  logic [IdxW-1:0]           hit_idx_q, hit_idx_d;
  logic [IdxW-1:0]           hit_age_q, hit_age_d;
  logic [lkv_pkg::ValW-1:0]  hit_val_q, hit_val_d;
  logic [IdxW-1:0]           old_idx_q, old_idx_d;
  logic [IdxW-1:0]           old_age_q, old_age_d;
  logic [lkv_pkg::KeyW-1:0]  old_key_q, old_key_d;
  logic [IdxW-1:0]           free_idx_q, free_idx_d;
  logic                      key_eq;

  // the one shared key comparator
  assign key_eq = (rd_key_i == key_i);

  always_comb begin
    flags_d    = flags_q;
    hit_idx_d  = hit_idx_q;
    hit_age_d  = hit_age_q;
    hit_val_d  = hit_val_q;
    old_idx_d  = old_idx_q;
    old_age_d  = old_age_q;
    old_key_d  = old_key_q;
    free_idx_d = free_idx_q;
    if (clr_i) begin
      flags_d = '0;
    end else if (en_i) begin
      if (ent_vld_i && key_eq && !flags_q.hit) begin
        flags_d.hit = 1'b1;
        hit_idx_d   = ent_idx_i;
        hit_age_d   = ent_age_i;
        hit_val_d   = rd_val_i;
      end
      if (ent_vld_i && (!flags_q.old_found || (ent_age_i > old_age_q))) begin
        flags_d.old_found = 1'b1;
        old_idx_d         = ent_idx_i;
        old_age_d         = ent_age_i;
        old_key_d         = rd_key_i;
      end
      if (!ent_vld_i && !flags_q.free_found) begin
        flags_d.free_found = 1'b1;
        free_idx_d         = ent_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    hit_age_q  <= hit_age_d;
    hit_val_q  <= hit_val_d;
    old_idx_q  <= old_idx_d;
    old_age_q  <= old_age_d;
    old_key_q  <= old_key_d;
    free_idx_q <= free_idx_d;
  end

  assign flags_o    = flags_q;
  assign hit_idx_o  = hit_idx_q;
  assign hit_age_o  = hit_age_q;
  assign hit_val_o  = hit_val_q;
  assign old_idx_o  = old_idx_q;
  assign old_key_o  = old_key_q;
  assign free_idx_o = free_idx_q;

endmodule

// File: hw/rtl/lru_key_value_cache.sv
// one request runs through the scan, drain and update states: key ram reads through the
// single key comparator, a drain state for the last read, then an update state that
// stalls while the previous result is untaken; the result word is registered at the update
// a new request is taken while the previous result still waits at the output
// reset (async, active low) empties the store, clears ages and occupancy, capacity = 5
module lru_key_value_cache #(
  parameter int unsigned Entries = lkv_pkg::EntriesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // key [31:0], value [63:32]
  input  logic [lkv_pkg::InDataW-1:0]    s_axis_tdata,
  // operation
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // hit [0], read_value [32:1], evicted [33], evicted_key [65:34], zero pad
  output logic [lkv_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lkv_pkg::CapW-1:0]       cfg_data_i
);

  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned OccW = $clog2(Entries + 1);
  localparam int unsigned CmpW = (OccW > lkv_pkg::CapW) ? OccW : lkv_pkg::CapW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  lkv_pkg::state_e state_q, state_d;

  logic                      op_q, op_d;
  logic [lkv_pkg::KeyW-1:0]  key_q, key_d;
  logic [lkv_pkg::ValW-1:0]  val_q, val_d;
  logic [IdxW-1:0]           rd_idx_q, rd_idx_d;
  logic                      cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]           cmp_idx_q, cmp_idx_d;
  logic [lkv_pkg::CapW-1:0]  cap_q, cap_d;
  logic [OccW-1:0]           occ_q, occ_d;
  logic [Entries-1:0]        valid_q, valid_d;
  logic [IdxW-1:0]           age_q [Entries];
  logic [IdxW-1:0]           age_d [Entries];

  logic                      out_vld_q, out_vld_d;
  logic                      out_hit_q, out_hit_d;
  logic [lkv_pkg::ValW-1:0]  out_rv_q, out_rv_d;
  logic                      out_ev_q, out_ev_d;
  logic [lkv_pkg::KeyW-1:0]  out_ek_q, out_ek_d;

  logic                      accept;
  logic                      in_ready;
  logic                      rd_en;
  logic                      commit;

  logic [lkv_pkg::KeyW-1:0]  rd_key;
  logic [lkv_pkg::ValW-1:0]  rd_val;
  lkv_pkg::flags_t           flags;
  logic [IdxW-1:0]           hit_idx, hit_age, old_idx, free_idx;
  logic [lkv_pkg::ValW-1:0]  hit_val;
  logic [lkv_pkg::KeyW-1:0]  old_key;

  logic [CmpW-1:0]           cap_ext, eff_cap, occ_ext;
  logic                      is_put, do_evict;
  logic [IdxW-1:0]           slot;

  // state machine: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkv_pkg::StIdle: begin
        if (accept) begin
          state_d = lkv_pkg::StScan;
        end
      end
      lkv_pkg::StScan: begin
        if (rd_idx_q == LastIdx) begin
          state_d = lkv_pkg::StDrain;
        end
      end
      lkv_pkg::StDrain: begin
        state_d = lkv_pkg::StUpdate;
      end
      lkv_pkg::StUpdate: begin
        if (commit) begin
          state_d = lkv_pkg::StIdle;
        end
      end
      default: begin
        state_d = lkv_pkg::StIdle;
      end
    endcase
  end

  // state machine: outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    commit   = 1'b0;
    unique case (state_q)
      lkv_pkg::StIdle: begin
        in_ready = 1'b1;
      end
      lkv_pkg::StScan: begin
        rd_en = 1'b1;
      end
      lkv_pkg::StDrain: begin
      end
      lkv_pkg::StUpdate: begin
        commit = !out_vld_q || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  assign accept        = s_axis_tvalid && in_ready;
  assign s_axis_tready = in_ready;
  assign cfg_ready_o   = 1'b1;

  // request capture and scan address
  always_comb begin
    op_d      = op_q;
    key_d     = key_q;
    val_d     = val_q;
    rd_idx_d  = rd_idx_q;
    cmp_vld_d = rd_en;
    cmp_idx_d = rd_idx_q;
    if (accept) begin
      op_d     = s_axis_tuser;
      key_d    = s_axis_tdata[31:0];
      val_d    = s_axis_tdata[63:32];
      rd_idx_d = '0;
    end else if (rd_en) begin
      rd_idx_d = IdxW'(rd_idx_q + 1'b1);
    end
  end

  lkv_ram #(
    .Width (lkv_pkg::KeyW),
    .Depth (Entries)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (commit && is_put),
    .waddr_i (slot),
    .wdata_i (key_q),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_key)
  );

  lkv_ram #(
    .Width (lkv_pkg::ValW),
    .Depth (Entries)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (commit && is_put),
    .waddr_i (slot),
    .wdata_i (val_q),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_val)
  );

  lkv_search #(
    .Entries (Entries)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (accept),
    .en_i       (cmp_vld_q),
    .key_i      (key_q),
    .rd_key_i   (rd_key),
    .rd_val_i   (rd_val),
    .ent_vld_i  (valid_q[cmp_idx_q]),
    .ent_age_i  (age_q[cmp_idx_q]),
    .ent_idx_i  (cmp_idx_q),
    .flags_o    (flags),
    .hit_idx_o  (hit_idx),
    .hit_age_o  (hit_age),
    .hit_val_o  (hit_val),
    .old_idx_o  (old_idx),
    .old_key_o  (old_key),
    .free_idx_o (free_idx)
  );

  // capacity clamp and eviction decision
  always_comb begin
    cap_ext = CmpW'(cap_q);
    occ_ext = CmpW'(occ_q);
    if (cap_q == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(Entries)) begin
      eff_cap = CmpW'(Entries);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign is_put   = (op_q == lkv_pkg::OpPut);
  assign do_evict = is_put && !flags.hit && flags.old_found && (occ_ext >= eff_cap);

  always_comb begin
    priority if (flags.hit) begin
      slot = hit_idx;
    end else if (do_evict) begin
      slot = old_idx;
    end else begin
      slot = free_idx;
    end
  end

  // entry state and capacity update
  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    occ_d   = occ_q;
    cap_d   = cap_q;
    if (cfg_valid_i) begin
      cap_d = cfg_data_i;
    end
    if (commit) begin
      if (flags.hit) begin
        for (int i = 0; i < Entries; i++) begin
          if (valid_q[i] && (age_q[i] < hit_age)) begin
            age_d[i] = IdxW'(age_q[i] + 1'b1);
          end
        end
        age_d[hit_idx] = '0;
      end else if (is_put && (do_evict || flags.free_found)) begin
        for (int i = 0; i < Entries; i++) begin
          if (valid_q[i] && (IdxW'(i) != slot)) begin
            age_d[i] = IdxW'(age_q[i] + 1'b1);
          end
        end
        age_d[slot]   = '0;
        valid_d[slot] = 1'b1;
        if (!do_evict) begin
          occ_d = OccW'(occ_q + 1'b1);
        end
      end
    end
  end

  // result register
  always_comb begin
    out_vld_d = out_vld_q;
    out_hit_d = out_hit_q;
    out_rv_d  = out_rv_q;
    out_ev_d  = out_ev_q;
    out_ek_d  = out_ek_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (commit) begin
      out_vld_d = 1'b1;
      out_hit_d = flags.hit;
      out_rv_d  = (!is_put && flags.hit) ? hit_val : lkv_pkg::MissValue;
      out_ev_d  = do_evict;
      out_ek_d  = do_evict ? old_key : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lkv_pkg::StIdle;
      cmp_vld_q <= 1'b0;
      cap_q     <= lkv_pkg::CapReset;
      occ_q     <= '0;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < Entries; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
      cap_q     <= cap_d;
      occ_q     <= occ_d;
      valid_q   <= valid_d;
      out_vld_q <= out_vld_d;
      age_q     <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    val_q     <= val_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    out_hit_q <= out_hit_d;
    out_rv_q  <= out_rv_d;
    out_ev_q  <= out_ev_d;
    out_ek_q  <= out_ek_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{lkv_pkg::OutPadW{1'b0}}, out_ek_q, out_ev_q, out_rv_q, out_hit_q};

endmodule
